### design/hsv_to_rgb_converter_macros.svh
// Assertion macros for the HSV to RGB converter checker.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define HSV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsv_to_rgb_converter assertion failed");

// Next-cycle implication, off while reset is held.
`define HSV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_converter assertion failed");

// Next-cycle implication, checked during reset too.
`define HSV_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_converter reset assertion failed");

`endif

### design/hsv2rgb_pkg.sv
// Shared constants and widths for the HSV to RGB converter.
// No dependencies.
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 17;
    localparam int CH_W      = 8;
    localparam int A_W       = FRAC_BITS + CH_W;
    localparam int B_W       = 2 * FRAC_BITS + 1;
    localparam int H6_W      = IN_W + 3;
    localparam int SEC_W     = H6_W - FRAC_BITS;
    localparam int HI_W      = A_W + FRAC_BITS + 1;
    localparam int LO_W      = A_W + FRAC_BITS;
    localparam int STAGES    = 4;

    localparam logic [IN_W-1:0] ONE    = IN_W'(1) << FRAC_BITS;
    localparam logic [B_W-1:0]  ONE_SQ = B_W'(1) << (2 * FRAC_BITS);

    localparam logic [SEC_W-1:0] SEC_1 = SEC_W'(1);
    localparam logic [SEC_W-1:0] SEC_2 = SEC_W'(2);
    localparam logic [SEC_W-1:0] SEC_3 = SEC_W'(3);
    localparam logic [SEC_W-1:0] SEC_4 = SEC_W'(4);
    localparam logic [SEC_W-1:0] SEC_5 = SEC_W'(5);

    typedef logic [CH_W-1:0] t_chan;

endpackage

### design/hsv_to_rgb_converter.sv
// HSV to RGB converter, one pixel per transfer, four register stages.
// A pixel passes the stage 1, 2, 3 and 4 registers in order on its way to the output.
// Throughput: one pixel per cycle; each stage holds only while the next is full.
// Reset (i_rst_n low, synchronous) empties all stages; payload is not cleared.
// Uses hsv2rgb_pkg and hsv2rgb_scale.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // hue[16:0], saturation[33:17], brightness[50:34]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_rdy;

    logic [IN_W-1:0]  w_h;
    logic [IN_W-1:0]  w_s;
    logic [IN_W-1:0]  w_v;
    logic [IN_W-1:0]  n_s;
    logic [IN_W-1:0]  n_v;
    logic [A_W:0]     n_a;
    logic [H6_W-1:0]  n_h6;

    logic [A_W-1:0]       r_s1_a;
    logic [IN_W-1:0]      r_s1_s;
    logic [SEC_W-1:0]     r_s1_sec;
    logic [FRAC_BITS-1:0] r_s1_f;
    logic                 r_s1_sz;

    logic [2*IN_W-1:0] n_kq;
    logic [2*IN_W-1:0] n_kt;
    logic [2*IN_W-1:0] n_bq;
    logic [2*IN_W-1:0] n_bt;
    logic [IN_W-1:0]   n_omf;

    logic [A_W-1:0]   r_s2_a;
    logic [B_W-1:0]   r_s2_bp;
    logic [B_W-1:0]   r_s2_bq;
    logic [B_W-1:0]   r_s2_bt;
    logic [SEC_W-1:0] r_s2_sec;
    logic             r_s2_sz;

    logic [SEC_W-1:0] r_s3_sec;
    logic             r_s3_sz;

    t_chan w_cv;
    t_chan w_cp;
    t_chan w_cq;
    t_chan w_ct;
    t_chan n_r;
    t_chan n_g;
    t_chan n_b;
    t_chan r_r;
    t_chan r_g;
    t_chan r_b;

    // a stage advances when it is empty or the next one advances
    always_comb begin
        w_rdy[STAGES-1] = ~r_vld[STAGES-1] | i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = ~r_vld[k] | w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: saturate, scale value by 255, split hue into sector and fraction
    assign w_h  = i_s_axis_tdata[IN_W-1:0];
    assign w_s  = i_s_axis_tdata[2*IN_W-1:IN_W];
    assign w_v  = i_s_axis_tdata[3*IN_W-1:2*IN_W];
    assign n_s  = (w_s > ONE) ? ONE : w_s;
    assign n_v  = (w_v > ONE) ? ONE : w_v;
    assign n_a  = ({n_v, 8'd0} - (A_W + 1)'(n_v));
    assign n_h6 = H6_W'({w_h, 2'b00}) + H6_W'({w_h, 1'b0});

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_a   <= n_a[A_W-1:0];
            r_s1_s   <= n_s;
            r_s1_sec <= n_h6[H6_W-1:FRAC_BITS];
            r_s1_f   <= n_h6[FRAC_BITS-1:0];
            r_s1_sz  <= (w_s == '0);
        end
    end

    // stage 2: form ONE^2 - k for each channel kind
    assign n_omf = ONE - IN_W'(r_s1_f);
    assign n_kq  = (2*IN_W)'(r_s1_s) * (2*IN_W)'(r_s1_f);
    assign n_kt  = (2*IN_W)'(r_s1_s) * (2*IN_W)'(n_omf);
    assign n_bq  = (2*IN_W)'(ONE_SQ) - n_kq;
    assign n_bt  = (2*IN_W)'(ONE_SQ) - n_kt;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_a   <= r_s1_a;
            r_s2_bp  <= {ONE - r_s1_s, {FRAC_BITS{1'b0}}};
            r_s2_bq  <= n_bq[B_W-1:0];
            r_s2_bt  <= n_bt[B_W-1:0];
            r_s2_sec <= r_s1_sec;
            r_s2_sz  <= r_s1_sz;
        end
    end

    // stage 3: partial products per channel, rounded sums feed stage 4
    hsv2rgb_scale u_scale_v (
        .i_clk  (i_clk),
        .i_en   (w_rdy[2]),
        .i_a    (r_s2_a),
        .i_b    (ONE_SQ),
        .o_chan (w_cv)
    );

    hsv2rgb_scale u_scale_p (
        .i_clk  (i_clk),
        .i_en   (w_rdy[2]),
        .i_a    (r_s2_a),
        .i_b    (r_s2_bp),
        .o_chan (w_cp)
    );

    hsv2rgb_scale u_scale_q (
        .i_clk  (i_clk),
        .i_en   (w_rdy[2]),
        .i_a    (r_s2_a),
        .i_b    (r_s2_bq),
        .o_chan (w_cq)
    );

    hsv2rgb_scale u_scale_t (
        .i_clk  (i_clk),
        .i_en   (w_rdy[2]),
        .i_a    (r_s2_a),
        .i_b    (r_s2_bt),
        .o_chan (w_ct)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_sec <= r_s2_sec;
            r_s3_sz  <= r_s2_sz;
        end
    end

    // stage 4: route channels by sector, gray on zero saturation
    always_comb begin
        if (r_s3_sz) begin
            n_r = w_cv;
            n_g = w_cv;
            n_b = w_cv;
        end else begin
            case (r_s3_sec)
                SEC_1: begin
                    n_r = w_cq; n_g = w_cv; n_b = w_cp;
                end
                SEC_2: begin
                    n_r = w_cp; n_g = w_cv; n_b = w_ct;
                end
                SEC_3: begin
                    n_r = w_cp; n_g = w_cq; n_b = w_cv;
                end
                SEC_4: begin
                    n_r = w_ct; n_g = w_cp; n_b = w_cv;
                end
                SEC_5: begin
                    n_r = w_cv; n_g = w_cp; n_b = w_cq;
                end
                default: begin
                    n_r = w_cv; n_g = w_ct; n_b = w_cp;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_r <= n_r;
            r_g <= n_g;
            r_b <= n_b;
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = {r_b, r_g, r_r};

endmodule

### design/hsv2rgb_scale.sv
// One channel product: round(a * b / ONE^3), half up.
// Registers the two partial products, then adds and rounds. Uses hsv2rgb_pkg.
module hsv2rgb_scale import hsv2rgb_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output t_chan          o_chan
);

    localparam logic [HI_W:0] HALF = (HI_W + 1)'(1) << (2 * FRAC_BITS - 1);

    logic [HI_W-1:0] r_hi;
    logic [LO_W-1:0] r_lo;
    logic [HI_W-1:0] n_hi;
    logic [LO_W-1:0] n_lo;
    logic [HI_W:0]   w_sum;

    assign n_hi = HI_W'(i_a) * HI_W'(i_b[B_W-1:FRAC_BITS]);
    assign n_lo = LO_W'(i_a) * LO_W'(i_b[FRAC_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign w_sum  = {1'b0, r_hi} + (HI_W + 1)'(r_lo >> FRAC_BITS) + HALF;
    assign o_chan = w_sum[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];

endmodule

### design/hsv2rgb_checker.sv
// Port-level checker for hsv_to_rgb_converter, attached by bind.
// Uses hsv_to_rgb_converter_macros.svh.
`include "hsv_to_rgb_converter_macros.svh"

module hsv2rgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        i_s_axis_tready,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready
);

    logic w_in_xfer;

    assign w_in_xfer = i_s_axis_tvalid && i_s_axis_tready;

    `HSV_ASSERT_NXT(a_out_hold, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid)
    `HSV_ASSERT_RST(a_rst_empty, !i_rst_n, !i_m_axis_tvalid)
    `HSV_ASSERT_IMP(a_empty_ready, !i_m_axis_tvalid, i_s_axis_tready)
    `HSV_ASSERT_NXT(a_latency, w_in_xfer ##0 i_m_axis_tready [*4], i_m_axis_tvalid)

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

### tb/hsv_to_rgb_converter_test.sv
// Self-checking testbench for hsv_to_rgb_converter: streams HSV pixels in and
// compares each RGB result with an exact fixed-point prediction of the conversion.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter RTL.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;
    import hsv2rgb_pkg::*;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] sat;
        logic [IN_W-1:0] val;
    } t_hsv;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;  // hue[16:0], saturation[33:17], brightness[50:34]
    logic        o_m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [23:0] o_m_axis_tdata;  // red[7:0], green[15:8], blue[23:16]

    t_hsv px_on_bus = '0;
    t_hsv hsv_pending[$];
    t_rgb rgb_due[$];

    int   gap_left = 0;
    int   stall_left = 0;
    logic tail_calm = 1'b0;
    int   pixels_total = 0;
    int   pixels_directed = 0;
    int   pixels_issued = 0;
    int   pixels_sent = 0;
    int   pixels_checked = 0;
    int   gray_seen = 0;
    int   clipped_seen = 0;
    int   mismatch_count = 0;
    int   sector_seen[7];

    assign i_s_axis_tdata = {5'b0, px_on_bus.val, px_on_bus.sat, px_on_bus.hue};

    hsv_to_rgb_converter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // round(a * b / ONE^3), half up
    function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] b);
        logic [63:0] b_hi;
        logic [63:0] b_lo;
        logic [63:0] x;
        b_hi = b >> FRAC_BITS;
        b_lo = b & ((64'd1 << FRAC_BITS) - 1);
        x = a * b_hi + ((a * b_lo) >> FRAC_BITS);
        return (x + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    endfunction

    function automatic t_rgb convert_pixel(t_hsv px);
        logic [63:0] one;
        logic [63:0] one_sq;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] h6;
        logic [63:0] sector;
        logic [63:0] f;
        logic [63:0] lvl_v;
        logic [63:0] lvl_p;
        logic [63:0] lvl_q;
        logic [63:0] lvl_t;
        t_rgb        c;
        one = 64'(ONE);
        one_sq = 64'(ONE_SQ);
        s = (64'(px.sat) > one) ? one : 64'(px.sat);
        v = (64'(px.val) > one) ? one : 64'(px.val);
        a = v * 255;
        h6 = 64'(px.hue) * 6;
        sector = h6 >> FRAC_BITS;
        f = h6 & (one - 1);
        lvl_v = scale_round(a, one_sq);
        lvl_p = scale_round(a, one_sq - s * one);
        lvl_q = scale_round(a, one_sq - s * f);
        lvl_t = scale_round(a, one_sq - s * (one - f));
        if (s == 0) begin
            c = '{lvl_v[7:0], lvl_v[7:0], lvl_v[7:0]};
        end else begin
            case (sector)
                1: begin
                    c = '{lvl_q[7:0], lvl_v[7:0], lvl_p[7:0]};
                end
                2: begin
                    c = '{lvl_p[7:0], lvl_v[7:0], lvl_t[7:0]};
                end
                3: begin
                    c = '{lvl_p[7:0], lvl_q[7:0], lvl_v[7:0]};
                end
                4: begin
                    c = '{lvl_t[7:0], lvl_p[7:0], lvl_v[7:0]};
                end
                5: begin
                    c = '{lvl_v[7:0], lvl_p[7:0], lvl_q[7:0]};
                end
                default: begin
                    c = '{lvl_v[7:0], lvl_t[7:0], lvl_p[7:0]};
                end
            endcase
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("[%0t] pixel %0d %s: expected %0d, got %0d",
                     $realtime, pixels_checked, what, want, got);
    endtask

    function automatic int pick_level();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'(ONE);
            2: return $urandom_range(int'(ONE) + 1, 131071);
            default: return $urandom_range(0, int'(ONE));
        endcase
    endfunction

    function automatic int pick_hue();
        int k;
        int h;
        case ($urandom_range(0, 9))
            7: begin
                k = $urandom_range(0, 6);
                h = (k * int'(ONE)) / 6 + $urandom_range(0, 4) - 2;
                return (h < 0) ? 0 : h;
            end
            8: return $urandom_range(int'(ONE) + 1, 131071);
            9: return $urandom_range(0, 1) ? int'(ONE) : 0;
            default: return $urandom_range(0, int'(ONE));
        endcase
    endfunction

    task automatic queue_pixel(int h, int s, int v);
        t_hsv px;
        px.hue = IN_W'(h);
        px.sat = IN_W'(s);
        px.val = IN_W'(v);
        hsv_pending.push_back(px);
    endtask

    always @(posedge i_clk) begin : drive_pixels
        t_hsv px;
        int   sec;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                rgb_due.push_back(convert_pixel(px_on_bus));
                pixels_sent++;
                sec = (int'(px_on_bus.hue) * 6) >> FRAC_BITS;
                sector_seen[(sec > 6) ? 6 : sec]++;
                if (px_on_bus.sat == 0)
                    gray_seen++;
                if (px_on_bus.sat > ONE || px_on_bus.val > ONE)
                    clipped_seen++;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (hsv_pending.size() > 0) begin
                    px = hsv_pending.pop_front();
                    pixels_issued++;
                    px_on_bus <= px;
                    s_valid <= 1'b1;
                    if (!tail_calm && $urandom_range(0, 5) == 0)
                        gap_left <= $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            tail_calm <= (pixels_issued >= pixels_total - 150);
        end
    end

    always @(posedge i_clk) begin : watch_rgb
        t_rgb got;
        t_rgb want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                got.red = o_m_axis_tdata[7:0];
                got.green = o_m_axis_tdata[15:8];
                got.blue = o_m_axis_tdata[23:16];
                if (rgb_due.size() == 0) begin
                    report_mismatch("with nothing outstanding, red", -1, int'(got.red));
                end else begin
                    want = rgb_due.pop_front();
                    if (got.red !== want.red)
                        report_mismatch("red", int'(want.red), int'(got.red));
                    if (got.green !== want.green)
                        report_mismatch("green", int'(want.green), int'(got.green));
                    if (got.blue !== want.blue)
                        report_mismatch("blue", int'(want.blue), int'(got.blue));
                    pixels_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (!tail_calm && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int one;
        one = int'(ONE);
        queue_pixel(0, 0, 0);
        queue_pixel(0, 0, one);
        queue_pixel(0, 0, 32768);
        queue_pixel(0, 0, 131071);
        queue_pixel(0, one, one);
        queue_pixel(one, one, one);
        queue_pixel(131071, 131071, 131071);
        queue_pixel(30000, one, 0);
        for (int k = 0; k < 6; k++) begin
            queue_pixel(((2 * k + 1) * one) / 12, one, one);
            queue_pixel(((2 * k + 1) * one) / 12, 40000, 50000);
        end
        queue_pixel(10922, one, 45000);
        queue_pixel(10923, one, 45000);
        queue_pixel(one - 1, one, one);
        pixels_directed = hsv_pending.size();
        for (int n = 0; n < 1150; n++)
            queue_pixel(pick_hue(), pick_level(), pick_level());
        pixels_total = hsv_pending.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (hsv_pending.size() > 0 || s_valid || rgb_due.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d of %0d pixels (%0d directed); gray %0d, clipped s/v %0d",
                 pixels_checked, pixels_sent, pixels_directed, gray_seen, clipped_seen);
        $display("Hue sectors 0..5: %0d %0d %0d %0d %0d %0d, sector six and above: %0d",
                 sector_seen[0], sector_seen[1], sector_seen[2], sector_seen[3],
                 sector_seen[4], sector_seen[5], sector_seen[6]);
        if (mismatch_count == 0 && rgb_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d pixels pending and %0d results outstanding",
                 hsv_pending.size(), rgb_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
